@@ src/mpct_pkg.sv @@
// ============================================================================
// mpct_pkg
// Shared types and constants of the masked point-cloud transform pipeline.
// ============================================================================
`default_nettype none

package mpct_pkg;

    localparam int SQ_STEPS  = 31;      // root bits of a 62-bit radicand
    localparam int DIV_STEPS = 16;      // quotient bits of the normal divide

    localparam logic [12:0] WIDTH_RESET  = 13'd1920;
    localparam logic [12:0] HEIGHT_RESET = 13'd1080;
    localparam logic [15:0] UNIT_MAX     = 16'd32767;

    typedef enum logic [2:0] {
        CFG_WIDTH  = 3'd0,
        CFG_HEIGHT = 3'd1,
        CFG_NORMAL = 3'd2,
        CFG_ROW_X  = 3'd3,
        CFG_ROW_Y  = 3'd4,
        CFG_ROW_Z  = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [12:0]      width;
        logic [12:0]      height;
        logic             normals_on;
        logic [2:0][63:0] rows;
    } cfg_t;

    // point result, colour and normal sign/zero flags that ride along
    typedef struct packed {
        logic [31:0] tx;
        logic [31:0] ty;
        logic [31:0] tz;
        logic [23:0] colour;
        logic [2:0]  neg;
        logic        zero;
    } side_t;

    typedef struct packed {
        side_t       sd;
        logic [2:0][31:0] a;
        logic [31:0] m;
    } mag_t;

    typedef struct packed {
        side_t       sd;
        logic [2:0][29:0] a;
    } carry_t;

    typedef struct packed {
        carry_t      c;
        logic [61:0] sq;
    } sqin_t;

    typedef struct packed {
        carry_t      c;
        logic [30:0] root;
    } divin_t;

    typedef struct packed {
        side_t       sd;
        logic [2:0][15:0] q;
    } res_t;

endpackage

`default_nettype wire

@@ src/masked_point_cloud_transform_top.sv @@
// ============================================================================
// masked_point_cloud_transform_top
// Masked depth-pixel filter with rigid transform and unit-normal output.
// ============================================================================
//
//  channel   direction  handshake             payload
//  in        sink       in_valid / in_ready   col line in_mask point_ok px py pz
//                                             colour nx ny nz normal_ok
//  out       source     out_valid / out_ready tx ty tz red green blue ntx nty ntz
//  cfg       sink       cfg_valid / cfg_ready cfg_index cfg_data
//
//  One word enters per cycle while no stall holds the pipeline; the normal path
//  runs through the 31-stage square root and the 17-stage divide.
//  Pixels outside the frame, unmasked or with a bad point are dropped at entry.
//  The whole pipeline advances while the output register is empty or taken;
//  a stall freezes every stage, so nothing is lost or repeated.
//  Reset clears all valid bits and loads the frame size defaults.
//  cfg_ready is always high; writes to unused indexes are ignored.
// ============================================================================
`default_nettype none

module masked_point_cloud_transform_top (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [11:0]         col,
    input  wire logic [11:0]         line,
    input  wire logic                in_mask,
    input  wire logic                point_ok,
    input  wire logic signed [31:0]  px,
    input  wire logic signed [31:0]  py,
    input  wire logic signed [31:0]  pz,
    input  wire logic [23:0]         colour,
    input  wire logic signed [15:0]  nx,
    input  wire logic signed [15:0]  ny,
    input  wire logic signed [15:0]  nz,
    input  wire logic                normal_ok,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic signed [31:0]       tx,
    output logic signed [31:0]       ty,
    output logic signed [31:0]       tz,
    output logic [7:0]               red,
    output logic [7:0]               green,
    output logic [7:0]               blue,
    output logic signed [15:0]       ntx,
    output logic signed [15:0]       nty,
    output logic signed [15:0]       ntz,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [63:0]         cfg_data
);
    import mpct_pkg::*;

    cfg_t            cfg_reg;
    logic            en;
    logic            fr_valid;
    mag_t            fr_data;
    logic            nm_valid;
    sqin_t           nm_data;
    logic            sq_valid;
    divin_t          sq_data;
    logic            dv_valid;
    res_t            dv_data;
    res_t            res_next;
    res_t            res_reg;
    logic            out_valid_reg;

    // advance everything unless a finished word is stuck at the output
    assign en        = !out_valid_reg || out_ready;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width      <= WIDTH_RESET;
            cfg_reg.height     <= HEIGHT_RESET;
            cfg_reg.normals_on <= 1'b0;
            cfg_reg.rows       <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_WIDTH:  cfg_reg.width      <= cfg_data[12:0];
                CFG_HEIGHT: cfg_reg.height     <= cfg_data[12:0];
                CFG_NORMAL: cfg_reg.normals_on <= cfg_data[0];
                CFG_ROW_X:  cfg_reg.rows[0]    <= cfg_data;
                CFG_ROW_Y:  cfg_reg.rows[1]    <= cfg_data;
                CFG_ROW_Z:  cfg_reg.rows[2]    <= cfg_data;
                default:    ;
            endcase
        end
    end

    mpct_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .col       (col),
        .line      (line),
        .in_mask   (in_mask),
        .point_ok  (point_ok),
        .px        (px),
        .py        (py),
        .pz        (pz),
        .colour    (colour),
        .nx        (nx),
        .ny        (ny),
        .nz        (nz),
        .normal_ok (normal_ok),
        .out_valid (fr_valid),
        .out_data  (fr_data)
    );

    mpct_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fr_valid),
        .in_data   (fr_data),
        .out_valid (nm_valid),
        .out_data  (nm_data)
    );

    mpct_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (nm_valid),
        .in_data   (nm_data),
        .out_valid (sq_valid),
        .out_data  (sq_data)
    );

    mpct_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .in_data   (sq_data),
        .out_valid (dv_valid),
        .out_data  (dv_data)
    );

    // clamp +1.0 to the largest code, apply the sign, drop absent normals
    always_comb
    begin
        logic [15:0] m;
        res_next.sd = dv_data.sd;
        for (int i = 0; i < 3; i++)
        begin
            m = (dv_data.q[i] > UNIT_MAX) ? UNIT_MAX : dv_data.q[i];
            if (dv_data.sd.zero)
                res_next.q[i] = '0;
            else if (dv_data.sd.neg[i])
                res_next.q[i] = 16'(-m);
            else
                res_next.q[i] = m;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign tx    = $signed(res_reg.sd.tx);
    assign ty    = $signed(res_reg.sd.ty);
    assign tz    = $signed(res_reg.sd.tz);
    assign red   = res_reg.sd.colour[7:0];
    assign green = res_reg.sd.colour[15:8];
    assign blue  = res_reg.sd.colour[23:16];
    assign ntx   = $signed(res_reg.q[0]);
    assign nty   = $signed(res_reg.q[1]);
    assign ntz   = $signed(res_reg.q[2]);

    // a held result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(res_reg))
        else $error("result register changed during stall");

    // minus one never reaches the most negative code
    a_no_min: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (ntx != 16'sh8000 && nty != 16'sh8000 && ntz != 16'sh8000))
        else $error("unit normal hit the most negative code");

    // an empty slot leaving the divider gives no result
    a_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        (en && !dv_valid) |=> !out_valid)
        else $error("result appeared from an empty slot");

endmodule

`default_nettype wire

@@ src/mpct_front.sv @@
// ============================================================================
// mpct_front
// Pixel filter, matrix multiply, rounding and saturation, normal magnitudes.
// ============================================================================
`default_nettype none

module mpct_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire mpct_pkg::cfg_t        cfg,
    input  wire logic                  in_valid,
    input  wire logic [11:0]           col,
    input  wire logic [11:0]           line,
    input  wire logic                  in_mask,
    input  wire logic                  point_ok,
    input  wire logic signed [31:0]    px,
    input  wire logic signed [31:0]    py,
    input  wire logic signed [31:0]    pz,
    input  wire logic [23:0]           colour,
    input  wire logic signed [15:0]    nx,
    input  wire logic signed [15:0]    ny,
    input  wire logic signed [15:0]    nz,
    input  wire logic                  normal_ok,
    output logic                       out_valid,
    output mpct_pkg::mag_t             out_data
);
    import mpct_pkg::*;

    logic                    keep;
    logic signed [47:0]      pp_next [3][3];
    logic signed [31:0]      np_next [3][3];
    logic signed [47:0]      pp_reg  [3][3];
    logic signed [31:0]      np_reg  [3][3];
    logic signed [15:0]      t1_reg  [3];
    logic [23:0]             col1_reg;
    logic                    nen1_reg;
    logic                    v1_reg;

    logic signed [51:0]      s_next [3];
    logic signed [33:0]      v_next [3];
    logic signed [51:0]      s_reg  [3];
    logic signed [33:0]      v_reg  [3];
    logic [23:0]             col2_reg;
    logic                    nen2_reg;
    logic                    v2_reg;

    mag_t                    mag_next;
    mag_t                    mag_reg;
    logic                    v3_reg;

    assign keep = in_valid && ({1'b0, col} < cfg.width) && ({1'b0, line} < cfg.height)
                  && in_mask && point_ok;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pp_next[i][0] = $signed(cfg.rows[i][15:0])  * px;
            pp_next[i][1] = $signed(cfg.rows[i][31:16]) * py;
            pp_next[i][2] = $signed(cfg.rows[i][47:32]) * pz;
            np_next[i][0] = $signed(cfg.rows[i][15:0])  * nx;
            np_next[i][1] = $signed(cfg.rows[i][31:16]) * ny;
            np_next[i][2] = $signed(cfg.rows[i][47:32]) * nz;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s_next[i] = 52'(pp_reg[i][0]) + 52'(pp_reg[i][1]) + 52'(pp_reg[i][2])
                      + $signed({{14{t1_reg[i][15]}}, t1_reg[i], 22'd0});
            v_next[i] = 34'(np_reg[i][0]) + 34'(np_reg[i][1]) + 34'(np_reg[i][2]);
        end
    end

    // round, saturate; take normal magnitudes and their largest
    always_comb
    begin
        logic signed [37:0] r [3];
        logic [31:0]        sat [3];
        logic [33:0]        mag [3];
        for (int i = 0; i < 3; i++)
        begin
            r[i] = 38'((s_reg[i] + 52'sd8192) >>> 14);
            if (r[i] > 38'sd2147483647)
                sat[i] = 32'h7FFF_FFFF;
            else if (r[i] < -38'sd2147483648)
                sat[i] = 32'h8000_0000;
            else
                sat[i] = r[i][31:0];
            mag[i] = v_reg[i][33] ? 34'(-v_reg[i]) : 34'(v_reg[i]);
            mag_next.a[i]  = mag[i][31:0];
            mag_next.sd.neg[i] = v_reg[i][33];
        end
        mag_next.sd.tx = sat[0];
        mag_next.sd.ty = sat[1];
        mag_next.sd.tz = sat[2];
        mag_next.sd.colour = col2_reg;
        mag_next.m = mag[0][31:0];
        if (mag[1][31:0] > mag_next.m)
            mag_next.m = mag[1][31:0];
        if (mag[2][31:0] > mag_next.m)
            mag_next.m = mag[2][31:0];
        mag_next.sd.zero = !nen2_reg || (mag_next.m == 32'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= keep;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_reg   <= pp_next;
            np_reg   <= np_next;
            for (int i = 0; i < 3; i++)
                t1_reg[i] <= $signed(cfg.rows[i][63:48]);
            col1_reg <= colour;
            nen1_reg <= cfg.normals_on && normal_ok;
            s_reg    <= s_next;
            v_reg    <= v_next;
            col2_reg <= col1_reg;
            nen2_reg <= nen1_reg;
            mag_reg  <= mag_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = mag_reg;

endmodule

`default_nettype wire

@@ src/mpct_norm.sv @@
// ============================================================================
// mpct_norm
// Power-of-two scaling of the normal magnitudes and sum of their squares.
// ============================================================================
`default_nettype none

module mpct_norm (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire mpct_pkg::mag_t     in_data,
    output logic                    out_valid,
    output mpct_pkg::sqin_t         out_data
);
    import mpct_pkg::*;

    logic [4:0]        top_next;
    logic [4:0]        top_reg;
    mag_t              d1_reg;
    carry_t            sh_next;
    carry_t            sh_reg;
    logic [59:0]       sq_reg [3];
    carry_t            d3_reg;
    sqin_t             sum_next;
    sqin_t             sum_reg;
    logic [3:0]        v_reg;

    // position of the leading one of the largest magnitude
    always_comb
    begin
        top_next = 5'd0;
        for (int i = 0; i < 32; i++)
            if (in_data.m[i])
                top_next = 5'(i);
    end

    // bring the leading one to bit 29, truncate on the way down
    always_comb
    begin
        logic [31:0] t;
        sh_next.sd = d1_reg.sd;
        for (int i = 0; i < 3; i++)
        begin
            if (top_reg > 5'd29)
                t = d1_reg.a[i] >> (top_reg - 5'd29);
            else
                t = d1_reg.a[i] << (5'd29 - top_reg);
            sh_next.a[i] = t[29:0];
        end
    end

    always_comb
    begin
        sum_next.c  = d3_reg;
        sum_next.sq = 62'(sq_reg[0]) + 62'(sq_reg[1]) + 62'(sq_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            top_reg <= top_next;
            d1_reg  <= in_data;
            sh_reg  <= sh_next;
            for (int i = 0; i < 3; i++)
                sq_reg[i] <= sh_reg.a[i] * sh_reg.a[i];
            d3_reg  <= sh_reg;
            sum_reg <= sum_next;
        end
    end

    assign out_valid = v_reg[3];
    assign out_data  = sum_reg;

endmodule

`default_nettype wire

@@ src/mpct_sqrt.sv @@
// ============================================================================
// mpct_sqrt
// Pipelined integer square root, one root bit per stage.
// ============================================================================
`default_nettype none

module mpct_sqrt (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire mpct_pkg::sqin_t    in_data,
    output logic                    out_valid,
    output mpct_pkg::divin_t        out_data
);
    import mpct_pkg::*;

    logic [33:0]  r_reg  [SQ_STEPS];
    logic [30:0]  q_reg  [SQ_STEPS];
    logic [61:0]  n_reg  [SQ_STEPS];
    carry_t       c_reg  [SQ_STEPS];
    logic         v_reg  [SQ_STEPS];
    logic [33:0]  r_next [SQ_STEPS];
    logic [30:0]  q_next [SQ_STEPS];

    always_comb
    begin
        logic [33:0] pr;
        logic [30:0] pq;
        logic [61:0] pn;
        logic [33:0] rr;
        logic [33:0] t;
        for (int k = 0; k < SQ_STEPS; k++)
        begin
            if (k == 0)
            begin
                pr = '0;
                pq = '0;
                pn = in_data.sq;
            end
            else
            begin
                pr = r_reg[k-1];
                pq = q_reg[k-1];
                pn = n_reg[k-1];
            end
            rr = {pr[31:0], pn[61-2*k -: 2]};
            t  = {1'b0, pq, 2'b01};
            if (rr >= t)
            begin
                r_next[k] = rr - t;
                q_next[k] = {pq[29:0], 1'b1};
            end
            else
            begin
                r_next[k] = rr;
                q_next[k] = {pq[29:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SQ_STEPS; k++)
                v_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int k = 1; k < SQ_STEPS; k++)
                v_reg[k] <= v_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg <= r_next;
            q_reg <= q_next;
            n_reg[0] <= in_data.sq;
            c_reg[0] <= in_data.c;
            for (int k = 1; k < SQ_STEPS; k++)
            begin
                n_reg[k] <= n_reg[k-1];
                c_reg[k] <= c_reg[k-1];
            end
        end
    end

    assign out_valid     = v_reg[SQ_STEPS-1];
    assign out_data.c    = c_reg[SQ_STEPS-1];
    assign out_data.root = q_reg[SQ_STEPS-1];

endmodule

`default_nettype wire

@@ src/mpct_div.sv @@
// ============================================================================
// mpct_div
// Three-lane pipelined rounded divide of scaled magnitudes by the norm.
// ============================================================================
`default_nettype none

module mpct_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire mpct_pkg::divin_t   in_data,
    output logic                    out_valid,
    output mpct_pkg::res_t          out_data
);
    import mpct_pkg::*;

    // numerator prep stage
    logic [45:0]  num_reg [3];
    logic [30:0]  den0_reg;
    side_t        sd0_reg;
    logic         v0_reg;

    logic [45:0]  rem_reg  [DIV_STEPS][3];
    logic [15:0]  q_reg    [DIV_STEPS][3];
    logic [30:0]  den_reg  [DIV_STEPS];
    side_t        sd_reg   [DIV_STEPS];
    logic         v_reg    [DIV_STEPS];
    logic [45:0]  rem_next [DIV_STEPS][3];
    logic [15:0]  q_next   [DIV_STEPS][3];

    always_comb
    begin
        logic [45:0] pr;
        logic [15:0] pq;
        logic [30:0] pd;
        logic [46:0] d;
        for (int j = 0; j < DIV_STEPS; j++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (j == 0)
                begin
                    pr = num_reg[i];
                    pq = '0;
                    pd = den0_reg;
                end
                else
                begin
                    pr = rem_reg[j-1][i];
                    pq = q_reg[j-1][i];
                    pd = den_reg[j-1];
                end
                d = {16'd0, pd} << (DIV_STEPS - 1 - j);
                if ({1'b0, pr} >= d)
                begin
                    rem_next[j][i] = pr - d[45:0];
                    q_next[j][i]   = {pq[14:0], 1'b1};
                end
                else
                begin
                    rem_next[j][i] = pr;
                    q_next[j][i]   = {pq[14:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            for (int j = 0; j < DIV_STEPS; j++)
                v_reg[j] <= 1'b0;
        end
        else if (en)
        begin
            v0_reg   <= in_valid;
            v_reg[0] <= v0_reg;
            for (int j = 1; j < DIV_STEPS; j++)
                v_reg[j] <= v_reg[j-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                num_reg[i] <= {1'b0, in_data.c.a[i], 15'd0} + 46'(in_data.root[30:1]);
            den0_reg <= in_data.root;
            sd0_reg  <= in_data.c.sd;
            rem_reg  <= rem_next;
            q_reg    <= q_next;
            den_reg[0] <= den0_reg;
            sd_reg[0]  <= sd0_reg;
            for (int j = 1; j < DIV_STEPS; j++)
            begin
                den_reg[j] <= den_reg[j-1];
                sd_reg[j]  <= sd_reg[j-1];
            end
        end
    end

    assign out_valid   = v_reg[DIV_STEPS-1];
    assign out_data.sd = sd_reg[DIV_STEPS-1];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            out_data.q[i] = q_reg[DIV_STEPS-1][i];
    end

endmodule

`default_nettype wire
